// ----- hdl/json_structure_tokenizer_assert.svh -----
// assertion macros for the json structure tokenizer
// used by the top level; no other dependencies
`ifndef JSON_STRUCTURE_TOKENIZER_ASSERT_SVH
`define JSON_STRUCTURE_TOKENIZER_ASSERT_SVH
// implication checked every clock, off during reset
`define JST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define JST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/jst_pkg.sv -----
// shared types and constants of the json structure tokenizer
// no dependencies
package jst_pkg;
  localparam int MaxDepth = 64;
  localparam int MaxTokens = 4096;
  localparam longint MaxDocBytes = 64'd16777216;
  localparam int OffW = 25;
  localparam int SlotW = 12;
  localparam int CntW = 13;

  typedef enum logic [2:0] {
    M_BETWEEN = 3'd0, M_STRING = 3'd1, M_ESCAPE = 3'd2, M_HEX = 3'd3, M_PRIM = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    K_OBJECT = 2'd0, K_ARRAY = 2'd1, K_STRING = 2'd2, K_PRIM = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_MALFORMED = 2'd1, ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic             record_kind;
    logic [SlotW-1:0] token_slot;
    logic [1:0]       token_kind;
    logic [OffW-1:0]  span_start;
    logic [OffW-1:0]  span_end;
    logic [SlotW-1:0] children;
    logic             has_parent;
    logic [SlotW-1:0] parent_slot;
    logic [1:0]       doc_status;
    logic [CntW-1:0]  token_total;
    logic             final_record;
  } rec_t;

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic is_esc(input logic [7:0] b);
    return b == 8'h22 || b == 8'h5c || b == 8'h2f || b == 8'h62 || b == 8'h66 ||
           b == 8'h6e || b == 8'h72 || b == 8'h74;
  endfunction
endpackage

// ----- hdl/jst_if.sv -----
// valid/ready channel interfaces for the tokenizer
// depends on jst_pkg
interface jst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] doc_byte;
  logic       doc_last;
  modport source (output valid, doc_byte, doc_last, input ready);
  modport sink (input valid, doc_byte, doc_last, output ready);
endinterface

interface jst_out_if;
  logic                       valid;
  logic                       ready;
  logic                       record_kind;
  logic [jst_pkg::SlotW-1:0]  token_slot;
  logic [1:0]                 token_kind;
  logic [jst_pkg::OffW-1:0]   span_start;
  logic [jst_pkg::OffW-1:0]   span_end;
  logic [jst_pkg::SlotW-1:0]  children;
  logic                       has_parent;
  logic [jst_pkg::SlotW-1:0]  parent_slot;
  logic [1:0]                 doc_status;
  logic [jst_pkg::CntW-1:0]   token_total;
  logic                       final_record;
  modport source (output valid, record_kind, token_slot, token_kind, span_start, span_end,
                  children, has_parent, parent_slot, doc_status, token_total,
                  final_record, input ready);
  modport sink (input valid, record_kind, token_slot, token_kind, span_start, span_end,
                children, has_parent, parent_slot, doc_status, token_total,
                final_record, output ready);
endinterface

// ----- hdl/jst_ram.sv -----
// generic single port write, single port read ram with registered read
// no dependencies
module jst_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/json_structure_tokenizer.sv -----
// json structure tokenizer top level
// depends on jst_pkg, jst_if, jst_ram and json_structure_tokenizer_assert.svh
//
// Takes one document byte per transfer and emits token records plus a final
// status record after the byte marked last. An input byte is taken in every
// cycle while the output queue has room for three records, so the sustained
// rate is one byte per clock; a byte may produce up to three records (a
// primitive, a closed container and the status record), drained one per
// ready cycle through an eight entry queue. Open containers sit in a stack
// memory (one entry per nesting level, registered read); the top of stack is
// kept in registers along with the entry below it, which a push takes from
// the old top and a pop refills by a memory read, so a pop that follows a
// push or pop in the next cycle sees the right data without a stall. The
// stack is not cleared: only entries below the current depth are ever read.
module json_structure_tokenizer #(
  parameter int MaxDepth = jst_pkg::MaxDepth
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [jst_pkg::CntW-1:0] cfg_wdata,
  jst_in_if.sink                  in_ch,
  jst_out_if.source               out_ch
);
  localparam int DepW = $clog2(MaxDepth + 1);
  localparam int AdrW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int EntW = 2 + jst_pkg::SlotW + jst_pkg::OffW + jst_pkg::SlotW;
  localparam int QD = 8;

  typedef struct packed {
    logic [1:0]                kind;
    logic [jst_pkg::SlotW-1:0] slot;
    logic [jst_pkg::OffW-1:0]  start;
    logic [jst_pkg::SlotW-1:0] children;
  } ent_t;

  // configuration and document state
  logic [jst_pkg::CntW-1:0] capacity;
  jst_pkg::mode_t           mode;
  logic [2:0]               hex_left;
  logic [jst_pkg::OffW-1:0] offset;
  logic [jst_pkg::CntW-1:0] used;
  logic [DepW-1:0]          depth;
  logic [jst_pkg::OffW-1:0] pend;
  logic [1:0]               err;
  // cached top of stack and the entry below it
  ent_t top, below;

  // next values
  jst_pkg::mode_t           mode_next;
  logic [2:0]               hex_left_next;
  logic [jst_pkg::CntW-1:0] used_next;
  logic [DepW-1:0]          depth_next;
  logic [jst_pkg::OffW-1:0] pend_next;
  logic [1:0]               err_next;
  ent_t                     top_next;
  logic                     push, pop;

  // records produced by this byte
  jst_pkg::rec_t rec [3];
  logic [1:0]    nrec;

  // output queue
  jst_pkg::rec_t q [QD];
  logic [2:0]    rd_ptr, wr_ptr;
  logic [3:0]    q_cnt;

  logic take;
  assign in_ch.ready = (q_cnt <= 4'(QD - 3));
  assign take = in_ch.valid && in_ch.ready;

  // stack memory: push writes the old top, pop refills from below
  logic              ram_we;
  logic [AdrW-1:0]   ram_waddr, ram_raddr;
  logic [EntW-1:0]   ram_wdata, ram_rdata;
  logic              pf_pending;

  jst_ram #(.Width(EntW), .Depth(MaxDepth)) u_stack (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // effective below entry: fresh memory read after a pop
  ent_t below_eff;
  assign below_eff = pf_pending ? ent_t'(ram_rdata) : below;

  always_comb begin
    logic [7:0]               b;
    logic [jst_pkg::OffW-1:0] pos;
    logic [jst_pkg::CntW-1:0] cap;
    logic                     leaf;
    logic [1:0]               leaf_kind;
    logic [jst_pkg::OffW-1:0] leaf_s, leaf_e;
    logic                     do_between;
    logic                     in_range;
    jst_pkg::rec_t            r;
    b = in_ch.doc_byte;
    pos = offset;
    cap = (capacity > jst_pkg::CntW'(jst_pkg::MaxTokens)) ?
          jst_pkg::CntW'(jst_pkg::MaxTokens) : capacity;
    mode_next = mode;
    hex_left_next = hex_left;
    used_next = used;
    depth_next = depth;
    pend_next = pend;
    err_next = err;
    top_next = top;
    push = 1'b0;
    pop = 1'b0;
    leaf = 1'b0;
    leaf_kind = jst_pkg::K_PRIM;
    leaf_s = pend;
    leaf_e = pos;
    do_between = 1'b0;
    nrec = 2'd0;
    r = '0;
    rec[0] = '0;
    rec[1] = '0;
    rec[2] = '0;
    in_range = {7'd0, offset} < 32'(jst_pkg::MaxDocBytes);

    if (err == jst_pkg::ST_OK) begin
      if (!in_range || capacity == '0) begin
        err_next = jst_pkg::ST_MALFORMED;
      end else begin
        case (mode)
          jst_pkg::M_PRIM: begin
            if (jst_pkg::is_space(b) || b == 8'h2c || b == 8'h5d || b == 8'h7d) begin
              mode_next = jst_pkg::M_BETWEEN;
              leaf = 1'b1;
              do_between = 1'b1;
            end else if (b < 8'h20 || b == 8'h3a || b == 8'h22 || b == 8'h5b ||
                         b == 8'h7b) begin
              err_next = jst_pkg::ST_MALFORMED;
            end
          end
          jst_pkg::M_STRING: begin
            if (b == 8'h22) begin
              mode_next = jst_pkg::M_BETWEEN;
              leaf = 1'b1;
              leaf_kind = jst_pkg::K_STRING;
            end else if (b < 8'h20) begin
              err_next = jst_pkg::ST_MALFORMED;
            end else if (b == 8'h5c) begin
              mode_next = jst_pkg::M_ESCAPE;
            end
          end
          jst_pkg::M_ESCAPE: begin
            if (b == 8'h75) begin
              mode_next = jst_pkg::M_HEX;
              hex_left_next = 3'd4;
            end else if (jst_pkg::is_esc(b)) begin
              mode_next = jst_pkg::M_STRING;
            end else begin
              err_next = jst_pkg::ST_MALFORMED;
            end
          end
          jst_pkg::M_HEX: begin
            if (!jst_pkg::is_hex(b)) begin
              err_next = jst_pkg::ST_MALFORMED;
            end else begin
              if (hex_left > 3'd1) hex_left_next = hex_left - 3'd1;
              else begin
                hex_left_next = 3'd0;
                mode_next = jst_pkg::M_STRING;
              end
            end
          end
          default: do_between = 1'b1;
        endcase

        // leaf allocation (string or primitive)
        if (leaf) begin
          if (used >= cap) begin
            err_next = jst_pkg::ST_FULL;
            do_between = 1'b0;
          end else begin
            r = '0;
            r.token_slot = used[jst_pkg::SlotW-1:0];
            r.token_kind = leaf_kind;
            r.span_start = leaf_s;
            r.span_end = leaf_e;
            r.has_parent = (depth != '0);
            r.parent_slot = (depth != '0) ? top.slot : '0;
            rec[nrec] = r;
            nrec = nrec + 2'd1;
            used_next = used + 1'b1;
            if (depth != '0) top_next.children = top.children + 1'b1;
          end
        end

        // structural byte handling between tokens
        if (do_between) begin
          if (jst_pkg::is_space(b) || b == 8'h3a || b == 8'h2c) begin
          end else if (b == 8'h7b || b == 8'h5b) begin
            if ({1'b0, depth} >= (DepW + 1)'(MaxDepth)) begin
              err_next = jst_pkg::ST_MALFORMED;
            end else if (used_next >= cap) begin
              err_next = jst_pkg::ST_FULL;
            end else begin
              push = 1'b1;
              // the parent's count must include this child: top_next already
              // holds any leaf update, so bump it before it goes to memory
              if (depth != '0) top_next.children = top_next.children + 1'b1;
              used_next = used_next + 1'b1;
              depth_next = depth + 1'b1;
            end
          end else if (b == 8'h7d || b == 8'h5d) begin
            if (depth == '0 ||
                top.kind != ((b == 8'h7d) ? jst_pkg::K_OBJECT : jst_pkg::K_ARRAY)) begin
              err_next = jst_pkg::ST_MALFORMED;
            end else begin
              pop = 1'b1;
              depth_next = depth - 1'b1;
              r = '0;
              r.token_slot = top_next.slot;
              r.token_kind = top_next.kind;
              r.span_start = top_next.start;
              r.span_end = pos + 1'b1;
              r.children = top_next.children;
              r.has_parent = (depth > DepW'(1));
              r.parent_slot = (depth > DepW'(1)) ? below_eff.slot : '0;
              rec[nrec] = r;
              nrec = nrec + 2'd1;
            end
          end else if (b == 8'h22) begin
            mode_next = jst_pkg::M_STRING;
            pend_next = pos + 1'b1;
          end else if (b < 8'h20) begin
            err_next = jst_pkg::ST_MALFORMED;
          end else begin
            mode_next = jst_pkg::M_PRIM;
            pend_next = pos;
          end
        end
      end
    end

    // end of document
    if (in_ch.doc_last) begin
      if (err_next == jst_pkg::ST_OK && mode_next == jst_pkg::M_PRIM) begin
        if (used_next >= cap) begin
          err_next = jst_pkg::ST_FULL;
        end else begin
          r = '0;
          r.token_slot = used_next[jst_pkg::SlotW-1:0];
          r.token_kind = jst_pkg::K_PRIM;
          r.span_start = pend_next;
          r.span_end = pos + 1'b1;
          r.has_parent = (depth_next != '0);
          r.parent_slot = (depth_next != '0) ? (pop ? below_eff.slot : top_next.slot) : '0;
          rec[nrec] = r;
          nrec = nrec + 2'd1;
          used_next = used_next + 1'b1;
          mode_next = jst_pkg::M_BETWEEN;
        end
      end
      if (err_next == jst_pkg::ST_OK &&
          (mode_next != jst_pkg::M_BETWEEN || depth_next != '0 || used_next == '0))
        err_next = jst_pkg::ST_MALFORMED;
      r = '0;
      r.record_kind = 1'b1;
      r.doc_status = err_next;
      r.token_total = (err_next == jst_pkg::ST_OK) ? used_next : '0;
      rec[nrec] = r;
      nrec = nrec + 2'd1;
    end
    if (nrec != 2'd0) rec[nrec - 2'd1].final_record = 1'b1;
  end

  // stack memory addressing: push stores the old top at depth-1, pop reads
  // depth-3 to refill below, push reads nothing new (below becomes old top)
  always_comb begin
    ram_we = take && push && (depth != '0);
    ram_waddr = AdrW'(depth - 1'b1);
    ram_wdata = EntW'(top_next);
    ram_raddr = AdrW'(depth - DepW'(3));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= jst_pkg::CntW'(jst_pkg::MaxTokens);
      mode <= jst_pkg::M_BETWEEN;
      hex_left <= '0;
      offset <= '0;
      used <= '0;
      depth <= '0;
      pend <= '0;
      err <= '0;
      pf_pending <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      // read data is valid only in the cycle right after the pop
      pf_pending <= take && !in_ch.doc_last && pop && (depth > DepW'(2));
      if (take && in_ch.doc_last) begin
        mode <= jst_pkg::M_BETWEEN;
        hex_left <= '0;
        offset <= '0;
        used <= '0;
        depth <= '0;
        pend <= '0;
        err <= '0;
      end else if (take) begin
        mode <= mode_next;
        hex_left <= hex_left_next;
        if ({7'd0, offset} < 32'(jst_pkg::MaxDocBytes)) offset <= offset + 1'b1;
        used <= used_next;
        depth <= depth_next;
        pend <= pend_next;
        err <= err_next;
      end
    end
  end

  // top and below cache
  always_ff @(posedge clk) begin
    if (take) begin
      if (push) begin
        top <= '{kind: (in_ch.doc_byte == 8'h7b) ? jst_pkg::K_OBJECT : jst_pkg::K_ARRAY,
                 slot: used_next[jst_pkg::SlotW-1:0] - 1'b1,
                 start: offset, children: '0};
        below <= top_next;
      end else if (pop) begin
        top <= below_eff;
      end else begin
        top <= top_next;
        below <= below_eff;
      end
    end else begin
      below <= below_eff;
    end
  end

  // output queue, written with up to three records per byte
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++)
        if (2'(i) < nrec) q[3'(wr_ptr + 3'(i))] <= rec[i];
    end
  end

  logic deq;
  assign deq = out_ch.valid && out_ch.ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      q_cnt <= '0;
    end else begin
      if (take) wr_ptr <= wr_ptr + 3'(nrec);
      if (deq) rd_ptr <= rd_ptr + 3'd1;
      q_cnt <= q_cnt + (take ? 4'(nrec) : 4'd0) - (deq ? 4'd1 : 4'd0);
    end
  end

  jst_pkg::rec_t head;
  assign head = q[rd_ptr];
  assign out_ch.valid = (q_cnt != '0);
  assign out_ch.record_kind = head.record_kind;
  assign out_ch.token_slot = head.token_slot;
  assign out_ch.token_kind = head.token_kind;
  assign out_ch.span_start = head.span_start;
  assign out_ch.span_end = head.span_end;
  assign out_ch.children = head.children;
  assign out_ch.has_parent = head.has_parent;
  assign out_ch.parent_slot = head.parent_slot;
  assign out_ch.doc_status = head.doc_status;
  assign out_ch.token_total = head.token_total;
  assign out_ch.final_record = head.final_record;

`include "json_structure_tokenizer_assert.svh"
  `JST_ASSERT_IMP(a_qcnt_bound, 1'b1, q_cnt <= 4'(QD))
  `JST_ASSERT_IMP(a_depth_bound, 1'b1, {1'b0, depth} <= (DepW + 1)'(MaxDepth))
  `JST_ASSERT_IMP(a_no_push_pop, take, !(push && pop))
  `JST_ASSERT_NEXT(a_last_clears, take && in_ch.doc_last, depth == '0 && used == '0)
endmodule

// ----- tb/tb_jst_checker.sv -----
// token record checker for the json structure tokenizer testbench
// depends on jst_pkg and jst_if; watches both channels and the capacity write port
module tb_jst_checker
  import jst_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [CntW-1:0] cfg_wdata,
  jst_in_if               in_ch,
  jst_out_if              out_ch,
  output int              mismatches,
  output int              pending,
  output int              checked
);
  timeunit 1ns;
  timeprecision 1ps;

  rec_t record_q[$];
  rec_t step_q[$];

  int      capacity;
  mode_t   mode;
  int      hex_left;
  longint  offset;
  int      used;
  int      depth;
  kind_t   open_kind[MaxDepth];
  int      open_slot[MaxDepth];
  longint  open_start[MaxDepth];
  int      open_children[MaxDepth];
  longint  pending_start;
  status_t doc_err;

  function automatic void clear_doc();
    mode = M_BETWEEN;
    hex_left = 0;
    offset = 0;
    used = 0;
    depth = 0;
    pending_start = 0;
    doc_err = ST_OK;
  endfunction

  function automatic void push_token(kind_t k, int slot, longint s, longint e, int ch);
    rec_t r;
    r = '0;
    r.token_slot = SlotW'(slot);
    r.token_kind = k;
    r.span_start = OffW'(s);
    r.span_end = OffW'(e);
    r.children = SlotW'(ch);
    if (depth > 0) begin
      r.has_parent = 1'b1;
      r.parent_slot = SlotW'(open_slot[depth-1]);
    end
    step_q.push_back(r);
  endfunction

  function automatic bit take_slot(output int slot);
    int lim;
    lim = (capacity > MaxTokens) ? MaxTokens : capacity;
    slot = 0;
    if (used >= lim) begin
      doc_err = ST_FULL;
      return 1'b0;
    end
    slot = used;
    used++;
    if (depth > 0) open_children[depth-1]++;
    return 1'b1;
  endfunction

  function automatic void close_leaf(kind_t k, longint s, longint e);
    int slot;
    if (take_slot(slot)) push_token(k, slot, s, e, 0);
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0d || b == 8'h0a;
  endfunction

  function automatic bit is_hexdig(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic void at_gap(logic [7:0] b, longint pos);
    int slot;
    kind_t want;
    if (is_blank(b) || b == ":" || b == ",") return;
    if (b == "{" || b == "[") begin
      if (depth >= MaxDepth) begin
        doc_err = ST_MALFORMED;
        return;
      end
      if (!take_slot(slot)) return;
      open_kind[depth] = (b == "{") ? K_OBJECT : K_ARRAY;
      open_slot[depth] = slot;
      open_start[depth] = pos;
      open_children[depth] = 0;
      depth++;
      return;
    end
    if (b == "}" || b == "]") begin
      want = (b == "}") ? K_OBJECT : K_ARRAY;
      if (depth == 0 || open_kind[depth-1] != want) begin
        doc_err = ST_MALFORMED;
        return;
      end
      depth--;
      // parent is now the entry below, which push_token picks up
      push_token(open_kind[depth], open_slot[depth], open_start[depth], pos + 1,
                 open_children[depth]);
      return;
    end
    if (b == 8'h22) begin
      mode = M_STRING;
      pending_start = pos + 1;
      return;
    end
    if (b < 8'h20) begin
      doc_err = ST_MALFORMED;
      return;
    end
    mode = M_PRIM;
    pending_start = pos;
  endfunction

  function automatic void take_byte(logic [7:0] b, longint pos);
    case (mode)
      M_PRIM: begin
        if (is_blank(b) || b == "," || b == "]" || b == "}") begin
          mode = M_BETWEEN;
          close_leaf(K_PRIM, pending_start, pos);
          if (doc_err == ST_OK) at_gap(b, pos);
        end else if (b < 8'h20 || b == ":" || b == 8'h22 || b == "[" || b == "{") begin
          doc_err = ST_MALFORMED;
        end
      end
      M_STRING: begin
        if (b == 8'h22) begin
          mode = M_BETWEEN;
          close_leaf(K_STRING, pending_start, pos);
        end else if (b < 8'h20) begin
          doc_err = ST_MALFORMED;
        end else if (b == 8'h5c) begin
          mode = M_ESCAPE;
        end
      end
      M_ESCAPE: begin
        if (b == "u") begin
          mode = M_HEX;
          hex_left = 4;
        end else if (b == 8'h22 || b == 8'h5c || b == "/" || b == "b" || b == "f" ||
                     b == "n" || b == "r" || b == "t") begin
          mode = M_STRING;
        end else begin
          doc_err = ST_MALFORMED;
        end
      end
      M_HEX: begin
        if (!is_hexdig(b)) begin
          doc_err = ST_MALFORMED;
        end else begin
          if (hex_left > 0) hex_left--;
          if (hex_left == 0) mode = M_STRING;
        end
      end
      default: at_gap(b, pos);
    endcase
  endfunction

  // work out the records caused by one accepted byte
  function automatic void predict(logic [7:0] b, logic last);
    longint pos;
    rec_t r;
    pos = offset;
    step_q.delete();
    if (doc_err == ST_OK) begin
      if (pos >= MaxDocBytes || capacity == 0) doc_err = ST_MALFORMED;
      else take_byte(b, pos);
    end
    if (offset < MaxDocBytes) offset++;
    if (last) begin
      if (doc_err == ST_OK && mode == M_PRIM) begin
        mode = M_BETWEEN;
        close_leaf(K_PRIM, pending_start, pos + 1);
      end
      if (doc_err == ST_OK && (mode != M_BETWEEN || depth != 0 || used == 0))
        doc_err = ST_MALFORMED;
      r = '0;
      r.record_kind = 1'b1;
      r.doc_status = doc_err;
      r.token_total = (doc_err == ST_OK) ? CntW'(used) : '0;
      step_q.push_back(r);
      clear_doc();
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].final_record = 1'b1;
    foreach (step_q[i]) record_q.push_back(step_q[i]);
  endfunction

  function automatic void check_record();
    rec_t got, want;
    string bad;
    got.record_kind = out_ch.record_kind;
    got.token_slot = out_ch.token_slot;
    got.token_kind = out_ch.token_kind;
    got.span_start = out_ch.span_start;
    got.span_end = out_ch.span_end;
    got.children = out_ch.children;
    got.has_parent = out_ch.has_parent;
    got.parent_slot = out_ch.parent_slot;
    got.doc_status = out_ch.doc_status;
    got.token_total = out_ch.token_total;
    got.final_record = out_ch.final_record;
    checked++;
    if (record_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected record %p", got);
      return;
    end
    want = record_q.pop_front();
    bad = "";
    if (got.record_kind !== want.record_kind) bad = {bad, " record_kind"};
    if (got.token_slot !== want.token_slot) bad = {bad, " token_slot"};
    if (got.token_kind !== want.token_kind) bad = {bad, " token_kind"};
    if (got.span_start !== want.span_start) bad = {bad, " span_start"};
    if (got.span_end !== want.span_end) bad = {bad, " span_end"};
    if (got.children !== want.children) bad = {bad, " children"};
    if (got.has_parent !== want.has_parent) bad = {bad, " has_parent"};
    if (got.parent_slot !== want.parent_slot) bad = {bad, " parent_slot"};
    if (got.doc_status !== want.doc_status) bad = {bad, " doc_status"};
    if (got.token_total !== want.token_total) bad = {bad, " token_total"};
    if (got.final_record !== want.final_record) bad = {bad, " final_record"};
    if (bad != "") begin
      mismatches++;
      if (mismatches <= 10) $display("record mismatch on%s\n  exp %p\n  got %p", bad, want, got);
    end
  endfunction

  initial begin
    mismatches = 0;
    checked = 0;
    pending = 0;
    capacity = MaxTokens;
    clear_doc();
  end

  always @(posedge clk) begin
    if (rst) begin
      capacity = MaxTokens;
      clear_doc();
      record_q.delete();
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (out_ch.valid && out_ch.ready) check_record();
      if (in_ch.valid && in_ch.ready) predict(in_ch.doc_byte, in_ch.doc_last);
    end
    pending = record_q.size();
  end
endmodule

// ----- tb/tb_json_structure_tokenizer.sv -----
// testbench top for the json structure tokenizer: clock, reset, stimulus, verdict
// depends on jst_pkg, jst_if, the tokenizer rtl and tb_jst_checker
module tb_json_structure_tokenizer;
  import jst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [CntW-1:0] cfg_wdata;

  jst_in_if  in_ch();
  jst_out_if out_ch();

  int mismatches, pending, checked;
  int docs_sent, bytes_sent;
  int burst_left;
  int max_gap;        // zero gives stretches of back to back transfers
  int hold_req;       // bumped by the stimulus to ask for a long receiver stall
  int hold_seen;

  json_structure_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  tb_jst_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("timeout with %0d records still expected", pending);
    $display("[json_structure_tokenizer] ERROR");
    $finish;
  end

  // receiver: switches between random stall patterns, with long holds on
  // request so the output queue fills and input backs up
  initial begin
    int style, left;
    out_ch.ready = 1'b0;
    hold_seen = 0;
    style = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        repeat (80) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left = $urandom_range(10, 60);
      end
      left--;
      case (style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 7) != 0);
        default: out_ch.ready <= (left % 4 == 0);
      endcase
    end
  end

  // one byte transfer, in bursts with random gaps between them
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.doc_byte <= b;
    in_ch.doc_last <= last;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_doc(ref logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    docs_sent++;
  endtask

  task automatic send_text(string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_doc(q);
  endtask

  // sender pause: hold off until every expected record has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_capacity(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= CntW'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_blank(ref logic [7:0] q[$]);
    if ($urandom_range(0, 3) == 0)
      q.push_back($urandom_range(0, 1) ? 8'h20 : ($urandom_range(0, 1) ? 8'h0a : 8'h09));
  endfunction

  function automatic void add_string(ref logic [7:0] q[$]);
    string hexdigs;
    hexdigs = "0123456789abcdefABCDEF";
    q.push_back(8'h22);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 5))
        0: begin
          q.push_back(8'h5c);
          q.push_back("u");
          repeat (4) q.push_back(hexdigs[$urandom_range(0, 21)]);
        end
        1: begin
          q.push_back(8'h5c);
          case ($urandom_range(0, 7))
            0: q.push_back(8'h22);
            1: q.push_back(8'h5c);
            2: q.push_back("/");
            3: q.push_back("b");
            4: q.push_back("f");
            5: q.push_back("n");
            6: q.push_back("r");
            default: q.push_back("t");
          endcase
        end
        default: begin
          logic [7:0] c;
          do c = 8'($urandom_range(8'h20, 8'hff)); while (c == 8'h22 || c == 8'h5c);
          q.push_back(c);
        end
      endcase
    end
    q.push_back(8'h22);
  endfunction

  function automatic void add_prim(ref logic [7:0] q[$]);
    string words[5];
    string w;
    words = '{"true", "false", "null", "-12.5e3", "7"};
    w = words[$urandom_range(0, 4)];
    for (int i = 0; i < w.len(); i++) q.push_back(w[i]);
  endfunction

  // well formed value with random content, nesting kept shallow
  function automatic void add_value(ref logic [7:0] q[$], input int lvl);
    int pick, n;
    pick = (lvl >= 3) ? $urandom_range(2, 3) : $urandom_range(0, 3);
    add_blank(q);
    case (pick)
      0: begin
        q.push_back("{");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) q.push_back(",");
          add_blank(q);
          add_string(q);
          q.push_back(":");
          add_value(q, lvl + 1);
        end
        q.push_back("}");
      end
      1: begin
        q.push_back("[");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) q.push_back(",");
          add_value(q, lvl + 1);
        end
        q.push_back("]");
      end
      2: add_string(q);
      default: add_prim(q);
    endcase
    add_blank(q);
  endfunction

  task automatic random_doc();
    logic [7:0] q[$];
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 13) begin
      // one or two top level values
      add_value(q, 0);
      if ($urandom_range(0, 2) == 0) begin
        q.push_back(" ");
        add_value(q, 0);
      end
    end else if (pick < 16) begin
      // broken: one byte replaced or the tail cut off
      add_value(q, 0);
      if ($urandom_range(0, 1)) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      else if (q.size() > 1) q = q[0:$urandom_range(0, q.size() - 2)];
    end else if (pick < 18) begin
      // noise over the full byte range
      repeat ($urandom_range(1, 5)) q.push_back(8'($urandom_range(0, 255)));
    end else if (pick == 18) begin
      // escape followed by any byte, zero included
      q = '{8'h22, 8'h5c};
      q.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
      q.push_back(8'h22);
    end else begin
      // nesting one level past the limit
      repeat (MaxDepth + 1) q.push_back("[");
      q.push_back("]");
    end
    send_doc(q);
  endtask

  initial begin
    int caps[6];
    int phase_bytes;
    logic [7:0] q[$];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.doc_byte = '0;
    in_ch.doc_last = 1'b0;
    docs_sent = 0;
    bytes_sent = 0;
    burst_left = 0;
    max_gap = 3;
    hold_req = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: nested object with hex escape, lone closer, top level primitive, control
    // byte in a string, primitive broken by a quote, wrong closer, blank document, 0xff byte
    send_text({"[{", 8'h22, "k", 8'h5c, "u0aF9", 8'h22, ":-1}]"});
    send_text("}");
    send_text("x");
    send_text({8'h22, 8'h01, 8'h22});
    send_text({"a", 8'h22});
    send_text("[}");
    send_text(" ");
    q = '{8'hff};
    send_doc(q);

    // capacity settings: the top of the 13-bit range, the smallest, zero and a few
    // mid values, ending at the reset value
    caps = '{8191, 1, 0, 3, 0, MaxTokens};
    caps[4] = $urandom_range(2, 20);
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      phase_bytes = 0;
      max_gap = (p % 2) ? 0 : 4;
      if (p == 0) begin
        // receiver stalls long while bytes keep coming; many records per document
        hold_req++;
        q.delete();
        q.push_back("[");
        for (int i = 0; i < 20; i++) begin
          if (i > 0) q.push_back(",");
          q.push_back(8'("0" + i % 10));
        end
        q.push_back("]");
        send_doc(q);
        drain();
      end
      while (phase_bytes < 22) begin
        int b0;
        b0 = bytes_sent;
        random_doc();
        phase_bytes += bytes_sent - b0;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d documents, %0d bytes sent, %0d records checked over six capacity settings",
             docs_sent, bytes_sent, checked);
    if (mismatches == 0 && pending == 0) begin
      $display("[json_structure_tokenizer] OK");
    end else begin
      $display("%0d mismatches, %0d records missing", mismatches, pending);
      $display("[json_structure_tokenizer] ERROR");
    end
    $finish;
  end
endmodule
